/* sv/plin_pkg.sv */
// Shared constants for the piecewise linear interpolator core.
`default_nettype none
package plin_pkg;

	localparam int COORD_W        = 32;
	localparam int FRAC_W         = 16;
	localparam int MAX_POINTS_DEF = 64;

	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 40;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] RANGE_INSIDE = 2'd0;
	localparam logic [STATUS_W-1:0] RANGE_BELOW  = 2'd1;
	localparam logic [STATUS_W-1:0] RANGE_ABOVE  = 2'd2;

endpackage
`default_nettype wire

/* sv/piecewise_linear_interpolator_core.sv */
// Clamped piecewise linear interpolator over a table of signed Q16.16 breakpoints.
//
//  Channel   Direction  Handshake               Contents
//  s_*       in         s_tvalid / s_tready     load a breakpoint or query an x value
//  m_*       out        m_tvalid / m_tready     interpolated y, segment and range status
//  cfg_*     in         cfg_we                  number of breakpoints in use
//
// A load transaction writes the table as it is accepted. A query scans the table for
// the first segment that holds x: the segment scan reads one table entry per cycle from
// the x memory port, and the interpolation runs the restoring divider on the shared subtractor.
// A zero-width segment skips the divider and returns the y of its first point.
// A query with no enclosing segment clamps to the y of the first or last point in use.
// The input is not ready while a query is in progress. The output register frees the
// block to take the next transaction while a result waits. Reset clears only control.
`default_nettype none
module piecewise_linear_interpolator_core #(
	parameter int MAX_POINTS = plin_pkg::MAX_POINTS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// point_index [5:0], x_value [37:6], y_value [69:38], zero [71:70]
	input  wire logic [plin_pkg::S_TDATA_W-1:0]   s_tdata,
	// action [0]
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// result_y [31:0], segment_found [37:32], range_status [39:38]
	output logic [plin_pkg::M_TDATA_W-1:0]        m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [plin_pkg::COUNT_W-1:0]     cfg_wdata
);

	localparam int CW    = plin_pkg::COORD_W;
	localparam int FW    = plin_pkg::FRAC_W;
	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW    = IDX_W + 1;
	localparam int DW    = CW + 2;
	localparam int QW    = FW + 1;
	localparam int PW    = (QW + 1) + (CW + 1);
	localparam int SHW   = PW - FW;
	localparam int SUMW  = SHW + 1;
	localparam int DCW   = $clog2(QW + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RD0    = 4'd1;
	localparam logic [3:0] ST_RD1    = 4'd2;
	localparam logic [3:0] ST_SCAN   = 4'd3;
	localparam logic [3:0] ST_FOUND  = 4'd4;
	localparam logic [3:0] ST_DX     = 4'd5;
	localparam logic [3:0] ST_DY     = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_MUL    = 4'd8;
	localparam logic [3:0] ST_ADD    = 4'd9;
	localparam logic [3:0] ST_CLAMP  = 4'd10;
	localparam logic [3:0] ST_CLAMPY = 4'd11;
	localparam logic [3:0] ST_DONE   = 4'd12;

	logic [3:0]                   state_q;
	logic [plin_pkg::COUNT_W-1:0] points_in_use_q;

	logic signed [CW-1:0] mem_x [MAX_POINTS];
	logic signed [CW-1:0] mem_y [MAX_POINTS];
	logic signed [CW-1:0] x_rd_q;
	logic signed [CW-1:0] y_rd_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 mem_we;

	logic signed [CW-1:0] qx_q;
	logic signed [CW-1:0] x0_q;
	logic signed [CW-1:0] prev_q;
	logic signed [CW-1:0] x1_q;
	logic signed [CW-1:0] y0_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        n_last;
	logic [NW-1:0]        k_q;
	logic [IDX_W-1:0]     seg_q;
	logic [CW-1:0]        w_q;
	logic [CW:0]          rem_q;
	logic [CW:0]          rem_sh;
	logic signed [CW:0]   dy_q;
	logic [QW-1:0]        quo_q;
	logic [DCW-1:0]       div_cnt_q;
	logic signed [PW-1:0] prod_q;
	logic [CW-1:0]        res_q;
	logic [plin_pkg::STATUS_W-1:0] status_q;

	logic signed [DW-1:0] sub_a;
	logic signed [DW-1:0] sub_b;
	logic signed [DW-1:0] sub_d;

	logic                  s_fire;
	logic                  out_free;
	logic                  below;
	logic                  hit;
	logic [NW-1:0]         n_next;
	logic signed [SHW-1:0] prod_sh;
	logic signed [SUMW-1:0] sum;
	logic                  ovf;
	logic [CW-1:0]         sat;

	logic [plin_pkg::INDEX_W-1:0] in_index;
	logic signed [CW-1:0]         in_x;
	logic signed [CW-1:0]         in_y;

	assign in_index = s_tdata[plin_pkg::INDEX_W-1:0];
	assign in_x     = s_tdata[plin_pkg::INDEX_W +: CW];
	assign in_y     = s_tdata[plin_pkg::INDEX_W + CW +: CW];

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign mem_we   = s_fire && (s_tuser == plin_pkg::ACT_LOAD)
		&& (int'(in_index) < MAX_POINTS);

	assign below  = (qx_q < x0_q);
	assign hit    = (qx_q >= prev_q) && (qx_q <= x_rd_q);
	assign n_last = n_q - NW'(1);
	assign rem_sh = (div_cnt_q == '0) ? rem_q : {rem_q[CW-1:0], 1'b0};

	always_comb begin
		if (points_in_use_q == '0) begin
			n_next = NW'(1);
		end else if (int'(points_in_use_q) > MAX_POINTS) begin
			n_next = NW'(MAX_POINTS);
		end else begin
			n_next = NW'(points_in_use_q);
		end
	end

	always_comb begin
		case (state_q)
			ST_RD0:   rd_addr = '0;
			ST_RD1:   rd_addr = IDX_W'(1);
			ST_SCAN:  rd_addr = k_q[IDX_W-1:0];
			ST_FOUND: rd_addr = seg_q;
			ST_DX:    rd_addr = seg_q + IDX_W'(1);
			ST_CLAMP: rd_addr = below ? '0 : n_last[IDX_W-1:0];
			default:  rd_addr = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_FOUND: begin
				sub_a = DW'(x1_q);
				sub_b = DW'(prev_q);
			end
			ST_DX: begin
				sub_a = DW'(qx_q);
				sub_b = DW'(prev_q);
			end
			ST_DY: begin
				sub_a = DW'(y_rd_q);
				sub_b = DW'(y0_q);
			end
			ST_DIV: begin
				sub_a = $signed({1'b0, rem_sh});
				sub_b = $signed({2'b00, w_q});
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign sub_d = sub_a - sub_b;

	assign prod_sh = prod_q[PW-1:FW];
	assign sum     = SUMW'(y0_q) + SUMW'(prod_sh);
	assign ovf     = !((&sum[SUMW-1:CW-1]) || (~|sum[SUMW-1:CW-1]));
	assign sat     = ovf ? (sum[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}})
		: sum[CW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_x[IDX_W'(in_index)] <= in_x;
			mem_y[IDX_W'(in_index)] <= in_y;
		end
		x_rd_q <= mem_x[rd_addr];
		y_rd_q <= mem_y[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_in_use_q <= plin_pkg::COUNT_W'(1);
		end else if (cfg_we) begin
			points_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_fire && (s_tuser == plin_pkg::ACT_QUERY)) begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0:    state_q <= ST_RD1;
				ST_RD1:    state_q <= (n_q == NW'(1)) ? ST_CLAMP : ST_SCAN;
				ST_SCAN: begin
					if (hit) begin
						state_q <= ST_FOUND;
					end else if (k_q == n_q) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_FOUND:  state_q <= ST_DX;
				ST_DX:     state_q <= ST_DY;
				ST_DY:     state_q <= (w_q == '0) ? ST_DONE : ST_DIV;
				ST_DIV:    state_q <= (div_cnt_q == DCW'(QW - 1)) ? ST_MUL : ST_DIV;
				ST_MUL:    state_q <= ST_ADD;
				ST_ADD:    state_q <= ST_DONE;
				ST_CLAMP:  state_q <= ST_CLAMPY;
				ST_CLAMPY: state_q <= ST_DONE;
				ST_DONE:   state_q <= out_free ? ST_IDLE : ST_DONE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				qx_q <= in_x;
				n_q  <= n_next;
			end
			ST_RD1: begin
				x0_q   <= x_rd_q;
				prev_q <= x_rd_q;
				seg_q  <= '0;
				k_q    <= NW'(2);
			end
			ST_SCAN: begin
				x1_q <= x_rd_q;
				if (!hit) begin
					prev_q <= x_rd_q;
					seg_q  <= seg_q + IDX_W'(1);
					k_q    <= k_q + NW'(1);
				end
			end
			ST_FOUND: begin
				w_q      <= sub_d[CW-1:0];
				status_q <= plin_pkg::RANGE_INSIDE;
			end
			ST_DX: begin
				rem_q <= sub_d[CW:0];
				y0_q  <= y_rd_q;
			end
			ST_DY: begin
				dy_q      <= sub_d[CW:0];
				res_q     <= y0_q;
				quo_q     <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				if (!sub_d[DW-1]) begin
					rem_q <= sub_d[CW:0];
				end else begin
					rem_q <= rem_sh;
				end
				quo_q     <= {quo_q[QW-2:0], !sub_d[DW-1]};
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			ST_MUL: begin
				prod_q <= $signed({1'b0, quo_q}) * dy_q;
			end
			ST_ADD: begin
				res_q <= sat;
			end
			ST_CLAMP: begin
				seg_q    <= '0;
				status_q <= below ? plin_pkg::RANGE_BELOW : plin_pkg::RANGE_ABOVE;
			end
			ST_CLAMPY: begin
				res_q <= y_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata <= {status_q, plin_pkg::INDEX_W'(seg_q), res_q};
		end
	end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the piecewise linear interpolator core: table loads, queries, point counts.
module testbench;

	localparam int POINTS = plin_pkg::MAX_POINTS_DEF;
	localparam int CW = plin_pkg::COORD_W;
	localparam int IW = plin_pkg::INDEX_W;
	localparam int SW = plin_pkg::STATUS_W;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 400;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	typedef struct {
		logic action;
		logic [IW-1:0] slot;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} request_t;

	typedef struct {
		logic [CW-1:0] y;
		logic [IW-1:0] segment;
		logic [SW-1:0] status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [plin_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [plin_pkg::M_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [plin_pkg::COUNT_W-1:0] cfg_wdata = '0;

	request_t pending_requests[$];
	answer_t expected_answers[$];
	request_t current;
	int requests_in_flight = 0;
	int requests_planned = 0;
	int mismatches = 0;
	int cycles = 0;
	bit s_fire = 1'b0;
	bit m_fire = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	logic signed [CW-1:0] table_x [POINTS];
	logic signed [CW-1:0] table_y [POINTS];
	logic [plin_pkg::COUNT_W-1:0] points_setting = 7'd1;
	logic signed [CW-1:0] plan_x [POINTS];
	logic signed [CW-1:0] plan_y [POINTS];

	piecewise_linear_interpolator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic answer_t interpolate(input logic signed [CW-1:0] qx);
		answer_t a;
		int used;
		int i;
		bit hit;
		longint q, x0, x1, y0, y1, frac, sum;
		q = qx;
		used = int'(points_setting);
		if (used < 1)
			used = 1;
		if (used > POINTS)
			used = POINTS;
		a.segment = '0;
		a.status = plin_pkg::RANGE_INSIDE;
		sum = 0;
		hit = 1'b0;
		for (i = 0; i + 1 < used && !hit; i++) begin
			x0 = table_x[i];
			x1 = table_x[i + 1];
			if (q >= x0 && q <= x1) begin
				y0 = table_y[i];
				y1 = table_y[i + 1];
				if (x1 == x0) begin
					sum = y0;
				end else begin
					frac = ((q - x0) <<< 16) / (x1 - x0);
					sum = y0 + ((frac * (y1 - y0)) >>> 16);
				end
				hit = 1'b1;
				a.segment = i[IW-1:0];
				a.status = plin_pkg::RANGE_INSIDE;
			end
		end
		if (!hit) begin
			if (q < longint'(table_x[0])) begin
				sum = table_y[0];
				a.status = plin_pkg::RANGE_BELOW;
			end else begin
				sum = table_y[used - 1];
				a.status = plin_pkg::RANGE_ABOVE;
			end
		end
		if (sum > COORD_MAX)
			sum = COORD_MAX;
		else if (sum < COORD_MIN)
			sum = COORD_MIN;
		a.y = sum[CW-1:0];
		return a;
	endfunction

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint pick_query_x(input int used);
		int i;
		int kind;
		longint lo, hi, span, rnd;
		kind = $urandom_range(0, 9);
		if (kind < 5 && used > 1) begin
			i = $urandom_range(0, used - 2);
			lo = plan_x[i];
			hi = plan_x[i + 1];
			if (lo > hi) begin
				span = lo;
				lo = hi;
				hi = span;
			end
			span = hi - lo + 1;
			rnd = longint'({$urandom, $urandom} >> 1);
			return lo + rnd % span;
		end
		if (kind == 5)
			return plan_x[$urandom_range(0, used - 1)];
		if (kind == 6)
			return longint'(plan_x[0]) - 1;
		if (kind == 7)
			return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		return longint'($signed($urandom));
	endfunction

	task automatic report_mismatch(input string what, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		mismatches++;
		$display("%0t: %s mismatch: got 0x%h, expected 0x%h", $time, what, got, want);
	endtask

	task automatic queue_request(input logic action, input int slot, input longint x,
			input longint y);
		request_t r;
		r.action = action;
		r.slot = slot[IW-1:0];
		r.x = x[CW-1:0];
		r.y = y[CW-1:0];
		if (action == plin_pkg::ACT_LOAD) begin
			plan_x[r.slot] = r.x;
			plan_y[r.slot] = r.y;
		end
		pending_requests.push_back(r);
		requests_in_flight++;
		requests_planned++;
	endtask

	task automatic drain(input int settle);
		while (requests_in_flight != 0 || expected_answers.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_points(input int value);
		drain(SETTLE_CYCLES);
		cfg_wdata <= value[plin_pkg::COUNT_W-1:0];
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		points_setting = value[plin_pkg::COUNT_W-1:0];
	endtask

	// Ascending tables over the full range or a narrow window, with repeated x values
	// now and then, or a table in random order.
	task automatic load_table(input int used);
		int i;
		int shape;
		longint x, step_max, yv;
		shape = $urandom_range(0, 9);
		if (shape < 4) begin
			x = COORD_MIN + $urandom_range(0, 1000);
			step_max = (2 * COORD_MAX - 1000) / used;
		end else begin
			x = longint'($signed($urandom)) / 2;
			step_max = 70000;
		end
		for (i = 0; i < used; i++) begin
			if (shape == 9)
				x = longint'($signed($urandom));
			if ($urandom_range(0, 7) == 0)
				yv = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			else
				yv = longint'($signed($urandom));
			queue_request(plin_pkg::ACT_LOAD, i, x, yv);
			if ($urandom_range(0, 7) != 0)
				x = x + $urandom_range(0, step_max);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		answer_t want;
		s_fire = arst_n && s_tvalid && s_tready;
		m_fire = arst_n && m_tvalid && m_tready;
		if (s_fire) begin
			requests_in_flight--;
			if (current.action == plin_pkg::ACT_LOAD) begin
				table_x[current.slot] = current.x;
				table_y[current.slot] = current.y;
			end else begin
				expected_answers.push_back(interpolate(current.x));
			end
		end
		if (m_fire) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[CW-1:0], '0);
			end else begin
				want = expected_answers.pop_front();
				if (m_tdata[CW-1:0] !== want.y)
					report_mismatch("result_y", m_tdata[CW-1:0], want.y);
				if (m_tdata[CW +: IW] !== want.segment)
					report_mismatch("segment_found", CW'(m_tdata[CW +: IW]),
						CW'(want.segment));
				if (m_tdata[CW + IW +: SW] !== want.status)
					report_mismatch("range_status", CW'(m_tdata[CW + IW +: SW]),
						CW'(want.status));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !s_fire) begin
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				current = pending_requests.pop_front();
				s_tdata <= {2'b00, current.y, current.x, current.slot};
				s_tuser <= current.action;
				s_tvalid <= 1'b1;
				send_gap = send_calm ? 0 : pick_pause();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (m_fire && !recv_calm)
				recv_stall = pick_pause();
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int n_cfg;
		int used;
		int q;
		int queries;
		int phase;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// With one point in use every query clamps to the first y.
		queue_request(plin_pkg::ACT_LOAD, 0, 0, COORD_MAX);
		queue_request(plin_pkg::ACT_QUERY, 0, -1, 0);
		queue_request(plin_pkg::ACT_QUERY, 0, 0, 0);
		queue_request(plin_pkg::ACT_QUERY, POINTS - 1, COORD_MAX, -1);
		queue_request(plin_pkg::ACT_QUERY, 0, COORD_MIN, 0);

		// A point count of zero behaves as one.
		write_points(0);
		queue_request(plin_pkg::ACT_QUERY, 0, 12345, 0);
		queue_request(plin_pkg::ACT_QUERY, 0, -12345, 0);

		// Zero-width first segment, a second segment spanning the full y range and an unsorted tail.
		write_points(4);
		queue_request(plin_pkg::ACT_LOAD, 0, 0, 123);
		queue_request(plin_pkg::ACT_LOAD, 1, 0, COORD_MIN);
		queue_request(plin_pkg::ACT_LOAD, 2, COORD_MAX, COORD_MAX);
		queue_request(plin_pkg::ACT_LOAD, 3, COORD_MIN, COORD_MIN);
		queue_request(plin_pkg::ACT_QUERY, 0, 0, 0);
		queue_request(plin_pkg::ACT_QUERY, 0, 1, 0);
		queue_request(plin_pkg::ACT_QUERY, 0, COORD_MAX, 0);
		queue_request(plin_pkg::ACT_QUERY, 0, 64'sh4000_0000, 0);
		queue_request(plin_pkg::ACT_QUERY, 0, -1, 0);

		phase = 0;
		while (requests_planned < ITEM_TARGET) begin
			case (phase)
				0: n_cfg = POINTS;
				1: n_cfg = 127;
				2: n_cfg = 2;
				3: n_cfg = POINTS + 1;
				default: n_cfg = ($urandom_range(0, 5) == 0) ? $urandom_range(1, POINTS)
					: $urandom_range(2, 8);
			endcase
			write_points(n_cfg);
			used = (n_cfg < 1) ? 1 : ((n_cfg > POINTS) ? POINTS : n_cfg);
			send_calm = ($urandom_range(0, 3) == 0);
			recv_calm = ($urandom_range(0, 3) == 0);
			load_table(used);
			if ($urandom_range(0, 2) == 0)
				drain(0);
			queries = $urandom_range(15, 35);
			for (q = 0; q < queries; q++) begin
				if ($urandom_range(0, 9) == 0)
					queue_request(plin_pkg::ACT_LOAD, $urandom_range(0, POINTS - 1),
						$signed($urandom), $signed($urandom));
				else
					queue_request(plin_pkg::ACT_QUERY, $urandom_range(0, POINTS - 1),
						pick_query_x(used), $signed($urandom));
			end
			phase++;
		end

		drain(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
